@@ rtl/tepq_pkg.sv @@
package tepq_pkg;

   // input mode codes
   typedef enum logic [1:0] {
      MODE_ADD_REL = 2'd0,
      MODE_ADD_ABS = 2'd1,
      MODE_TICK    = 2'd2
   } mode_type;

   // result kind codes
   typedef enum logic {
      KIND_FIRED   = 1'b0,
      KIND_DROPPED = 1'b1
   } kind_type;

   // classified operation handed from front to back
   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_TICK = 1'b1
   } state_type;

   // time holds the wake time for an add and the current time for a tick
   typedef struct packed {
      op_type      op;
      logic [15:0] target;
      logic [7:0]  evtype;
      logic [31:0] time_ms;
   } cmd_type;

   typedef struct packed {
      logic [31:0] wake;
      logic [15:0] target;
      logic [7:0]  evtype;
   } entry_type;

   // most results one tick releases
   localparam int MAX_OUT = 16;
   localparam int EMIT_W = $clog2(MAX_OUT);

   // slots of the command queue between front and back (power of two)
   localparam int CMD_SLOTS = 2;
   localparam int CMD_PTR_W = $clog2(CMD_SLOTS);
   localparam int CMD_CNT_W = $clog2(CMD_SLOTS + 1);

endpackage

@@ rtl/tepq_front.sv @@
module tepq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [15:0]       req_target_id,
   input  logic [7:0]        req_event_type,
   input  logic [31:0]       req_time_value,
   input  logic [31:0]       req_now_ms,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output tepq_pkg::cmd_type cmd
);

   logic              cmd_valid_ff;
   logic              cmd_valid_in;
   tepq_pkg::cmd_type cmd_ff;
   tepq_pkg::cmd_type cmd_in;
   logic              accept;

   assign req_ready = !cmd_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      cmd_in       = cmd_ff;
      if (accept) begin
         cmd_in.target = req_target_id;
         cmd_in.evtype = req_event_type;
         unique case (tepq_pkg::mode_type'(req_mode))
            tepq_pkg::MODE_ADD_REL: begin
               cmd_valid_in   = 1'b1;
               cmd_in.op      = tepq_pkg::OP_ADD;
               // wraps modulo 2^32
               cmd_in.time_ms = req_now_ms + req_time_value;
            end
            tepq_pkg::MODE_ADD_ABS: begin
               cmd_valid_in   = 1'b1;
               cmd_in.op      = tepq_pkg::OP_ADD;
               cmd_in.time_ms = req_time_value;
            end
            tepq_pkg::MODE_TICK: begin
               cmd_valid_in   = 1'b1;
               cmd_in.op      = tepq_pkg::OP_TICK;
               cmd_in.time_ms = req_now_ms;
            end
            default: begin
               // unused mode: transaction taken and dropped
               cmd_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

@@ rtl/tepq_queue.sv @@
module tepq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tepq_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tepq_pkg::cmd_type pop_cmd
);

   tepq_pkg::cmd_type                     slot_ff [tepq_pkg::CMD_SLOTS];
   logic [tepq_pkg::CMD_PTR_W-1:0]        wr_ptr_ff;
   logic [tepq_pkg::CMD_PTR_W-1:0]        wr_ptr_in;
   logic [tepq_pkg::CMD_PTR_W-1:0]        rd_ptr_ff;
   logic [tepq_pkg::CMD_PTR_W-1:0]        rd_ptr_in;
   logic [tepq_pkg::CMD_CNT_W-1:0]        count_ff;
   logic [tepq_pkg::CMD_CNT_W-1:0]        count_in;
   logic                                  do_push;
   logic                                  do_pop;

   assign push_ready = count_ff != tepq_pkg::CMD_CNT_W'(tepq_pkg::CMD_SLOTS);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/tepq_back.sv @@
module tepq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  tepq_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [15:0]       rsp_out_target,
   output logic [7:0]        rsp_out_type,
   output logic              rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tepq_pkg::entry_type         entry_ff [QUEUE_DEPTH];
   tepq_pkg::entry_type         entry_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   tepq_pkg::state_type         state_ff;
   tepq_pkg::state_type         state_in;
   logic [31:0]                 now_ff;
   logic [31:0]                 now_in;
   logic [tepq_pkg::EMIT_W-1:0] emit_ff;
   logic [tepq_pkg::EMIT_W-1:0] emit_in;
   logic [QUEUE_DEPTH-1:0]      later;
   logic                        out_free;
   logic                        due;
   logic                        tick_last;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        load;
   tepq_pkg::kind_type          kind_ff;
   tepq_pkg::kind_type          kind_in;
   logic [15:0]                 target_ff;
   logic [15:0]                 target_in;
   logic [7:0]                  type_ff;
   logic [7:0]                  type_in;
   logic                        last_ff;
   logic                        last_in;

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_target = target_ff;
   assign rsp_out_type   = type_ff;
   assign rsp_last       = last_ff;

   // valid entries that sort behind the incoming wake time
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         later[i] = (CNT_W'(i) < count_ff) && (entry_ff[i].wake > cmd.time_ms);
      end
   end

   assign due       = (count_ff != '0) && (entry_ff[0].wake <= now_ff);
   assign tick_last = (emit_ff == tepq_pkg::EMIT_W'(tepq_pkg::MAX_OUT - 1))
                      || (count_ff == CNT_W'(1)) || (entry_ff[1].wake > now_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      entry_in  = entry_ff;
      now_in    = now_ff;
      emit_in   = emit_ff;
      cmd_ready = 1'b0;
      load      = 1'b0;
      kind_in   = tepq_pkg::KIND_FIRED;
      target_in = entry_ff[0].target;
      type_in   = entry_ff[0].evtype;
      last_in   = tick_last;
      unique case (state_ff)
         tepq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  tepq_pkg::OP_ADD: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        if (out_free) begin
                           cmd_ready = 1'b1;
                           load      = 1'b1;
                           kind_in   = tepq_pkg::KIND_DROPPED;
                           target_in = cmd.target;
                           type_in   = cmd.evtype;
                           last_in   = 1'b1;
                        end
                     end else begin
                        cmd_ready = 1'b1;
                        count_in  = count_ff + 1'b1;
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           if (i > 0 && later[(i > 0) ? i - 1 : 0]) begin
                              entry_in[i] = entry_ff[(i > 0) ? i - 1 : 0];
                           end else if ((i == 0 || !later[(i > 0) ? i - 1 : 0]) &&
                                        (later[i] || CNT_W'(i) == count_ff)) begin
                              entry_in[i].wake   = cmd.time_ms;
                              entry_in[i].target = cmd.target;
                              entry_in[i].evtype = cmd.evtype;
                           end
                        end
                     end
                  end
                  tepq_pkg::OP_TICK: begin
                     cmd_ready = 1'b1;
                     now_in    = cmd.time_ms;
                     emit_in   = '0;
                     state_in  = tepq_pkg::ST_TICK;
                  end
               endcase
            end
         end
         tepq_pkg::ST_TICK: begin
            if (!due) begin
               state_in = tepq_pkg::ST_IDLE;
            end else if (out_free) begin
               load     = 1'b1;
               count_in = count_ff - 1'b1;
               emit_in  = emit_ff + 1'b1;
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  entry_in[i] = entry_ff[i + 1];
               end
               if (tick_last) begin
                  state_in = tepq_pkg::ST_IDLE;
               end
            end
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tepq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      now_ff   <= now_in;
      emit_ff  <= emit_in;
      if (load) begin
         kind_ff   <= kind_in;
         target_ff <= target_in;
         type_ff   <= type_in;
         last_ff   <= last_in;
      end
   end

endmodule

@@ rtl/timed_event_priority_queue_unit.sv @@
// channel  direction  fields                                            handshake
// req      in         mode, target_id, event_type, time_value, now_ms   req_valid / req_ready
// rsp      out        kind, out_target, out_type, last                  rsp_valid / rsp_ready
//
// an add passes the front register and the command queue, then is inserted in
// the sorted shift chain
// a tick sets the current time and enters the tick state, then releases
// due events as rsp_ready allows (up to 16), or ends with no result if none is due
// reset clears the entry count and the queues; stored entries need no clearing
// the front keeps taking transactions while the back waits on rsp_ready,
// until the two-slot command queue and the front register fill
module timed_event_priority_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_target_id,
   input  logic [7:0]  req_event_type,
   input  logic [31:0] req_time_value,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_out_target,
   output logic [7:0]  rsp_out_type,
   output logic        rsp_last
);

   logic              front_valid;
   logic              front_ready;
   tepq_pkg::cmd_type front_cmd;
   logic              back_valid;
   logic              back_ready;
   tepq_pkg::cmd_type back_cmd;

   tepq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_target_id  (req_target_id),
      .req_event_type (req_event_type),
      .req_time_value (req_time_value),
      .req_now_ms     (req_now_ms),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   tepq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   tepq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (back_valid),
      .cmd_ready      (back_ready),
      .cmd            (back_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_target (rsp_out_target),
      .rsp_out_type   (rsp_out_type),
      .rsp_last       (rsp_last)
   );

endmodule

@@ tb/timed_event_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps

module timed_event_priority_queue_unit_tb;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 30;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      tepq_pkg::kind_type kind;
      logic [15:0]        target;
      logic [7:0]         evtype;
      logic               last;
   } fire_result_type;

   // keeps its own sorted copy of the timer store and the results it owes
   class timer_queue_scoreboard;
      tepq_pkg::entry_type slots[$];
      fire_result_type     due_results[$];
      int                  error_count = 0;

      function void note_request(logic [1:0] mode, logic [15:0] tgt, logic [7:0] typ,
                                 logic [31:0] tval, logic [31:0] now);
         logic [31:0]         wt;
         tepq_pkg::entry_type e;
         fire_result_type     r;
         int                  pos;
         int                  n;
         if (mode == tepq_pkg::MODE_ADD_REL || mode == tepq_pkg::MODE_ADD_ABS) begin
            wt = (mode == tepq_pkg::MODE_ADD_REL) ? now + tval : tval;
            if (slots.size() >= DEPTH) begin
               r.kind = tepq_pkg::KIND_DROPPED;
               r.target = tgt;
               r.evtype = typ;
               r.last = 1'b1;
               due_results.push_back(r);
            end else begin
               // new entry goes behind every entry of equal wake time
               pos = slots.size();
               while (pos > 0 && slots[pos - 1].wake > wt) pos--;
               e.wake = wt;
               e.target = tgt;
               e.evtype = typ;
               slots.insert(pos, e);
            end
         end else if (mode == tepq_pkg::MODE_TICK) begin
            n = 0;
            while (n < slots.size() && n < tepq_pkg::MAX_OUT && slots[n].wake <= now) n++;
            for (int i = 0; i < n; i++) begin
               e = slots.pop_front();
               r.kind = tepq_pkg::KIND_FIRED;
               r.target = e.target;
               r.evtype = e.evtype;
               r.last = (i + 1 == n);
               due_results.push_back(r);
            end
         end
      endfunction

      function void check_result(logic kind, logic [15:0] tgt, logic [7:0] typ, logic last);
         fire_result_type r;
         if (due_results.size() == 0) begin
            $error("result with nothing pending: kind %0d target %h type %h last %0d",
                   kind, tgt, typ, last);
            error_count++;
         end else begin
            r = due_results.pop_front();
            if (r.kind != kind) begin
               $error("kind: expected %0d, got %0d", r.kind, kind);
               error_count++;
            end
            if (r.target != tgt) begin
               $error("out_target: expected %h, got %h", r.target, tgt);
               error_count++;
            end
            if (r.evtype != typ) begin
               $error("out_type: expected %h, got %h", r.evtype, typ);
               error_count++;
            end
            if (r.last != last) begin
               $error("last: expected %0d, got %0d", r.last, last);
               error_count++;
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [15:0] req_target_id = '0;
   logic [7:0]  req_event_type = '0;
   logic [31:0] req_time_value = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_out_target;
   logic [7:0]  rsp_out_type;
   logic        rsp_last;

   timer_queue_scoreboard sb;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_cycles = 0;
   logic [31:0] clock_ms;

   timed_event_priority_queue_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_target_id(req_target_id),
      .req_event_type(req_event_type),
      .req_time_value(req_time_value),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_target(rsp_out_target),
      .rsp_out_type(rsp_out_type),
      .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   // receiver: a long hold-off takes precedence over random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_kind, rsp_out_target, rsp_out_type, rsp_last);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timed_event_priority_queue_unit_tb: errors");
      $finish;
   end

   task automatic send_item(logic [1:0] m, logic [15:0] tgt, logic [7:0] typ,
                            logic [31:0] tval, logic [31:0] now);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_target_id <= tgt;
      req_event_type <= typ;
      req_time_value <= tval;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      sb.note_request(m, tgt, typ, tval, now);
   endtask

   task automatic lower_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // adds still in flight give no result, so let the pipeline settle
   task automatic wait_for_drain();
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed traffic around a running clock, with some wide values
   task automatic random_item(output bit counted);
      logic [1:0]  m;
      logic [31:0] tv;
      logic [31:0] now;
      int          r;
      r = $urandom_range(99);
      tv = $urandom;
      now = $urandom;
      if (r < 4) begin
         m = MODE_UNUSED;
      end else if (r < 42) begin
         m = tepq_pkg::MODE_ADD_REL;
         now = clock_ms;
         if ($urandom_range(9) != 0) tv = $urandom_range(60);
      end else if (r < 62) begin
         m = tepq_pkg::MODE_ADD_ABS;
         if ($urandom_range(9) != 0) tv = clock_ms + $urandom_range(60);
      end else begin
         m = tepq_pkg::MODE_TICK;
         clock_ms = clock_ms + $urandom_range(25);
         if ($urandom_range(9) != 0) now = clock_ms;
      end
      send_item(m, 16'($urandom), 8'($urandom), tv, now);
      counted = (m != MODE_UNUSED);
   endtask

   initial begin
      int count;
      bit counted;
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty store, extremes, wrapped relative time, ties and unused mode
      send_item(tepq_pkg::MODE_TICK, 16'h1234, 8'h56, 32'h0, 32'h0);
      send_item(tepq_pkg::MODE_ADD_ABS, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'h0);
      send_item(tepq_pkg::MODE_ADD_ABS, 16'h0000, 8'h00, 32'h0, 32'hFFFF_FFFF);
      send_item(tepq_pkg::MODE_ADD_REL, 16'h1111, 8'h11, 32'h20, 32'hFFFF_FFF0);
      send_item(tepq_pkg::MODE_ADD_ABS, 16'h2222, 8'h22, 32'h10, 32'h5555_5555);
      send_item(MODE_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(tepq_pkg::MODE_ADD_REL, 16'h3333, 8'h33, 32'h0, 32'h10);
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'hF);
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'h10);
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'hFFFF_FFFE);
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'hFFFF_FFFF);

      // fill the store with equal wake times, then overflow it
      for (int i = 0; i < DEPTH; i++) begin
         if (i % 2 == 0)
            send_item(tepq_pkg::MODE_ADD_ABS, 16'hA000 + 16'(i), 8'h80 + 8'(i),
                      32'd5, 32'd0);
         else
            send_item(tepq_pkg::MODE_ADD_REL, 16'hA000 + 16'(i), 8'h80 + 8'(i),
                      32'd3, 32'd2);
      end
      send_item(tepq_pkg::MODE_ADD_ABS, 16'hBEEF, 8'hEE, 32'd1, 32'd0);
      send_item(tepq_pkg::MODE_ADD_REL, 16'h0F0F, 8'h0F, 32'd0, 32'd0);

      // receiver holds off while sixteen results pile up and more items arrive
      hold_cycles = 300;
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'd5);
      for (int i = 0; i < 4; i++)
         send_item(tepq_pkg::MODE_ADD_ABS, 16'hC000 + 16'(i), 8'hC0 + 8'(i),
                   32'd100 - 32'(i), 32'd0);
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'd98);
      send_item(tepq_pkg::MODE_TICK, 16'h0, 8'h0, 32'h0, 32'd100);
      lower_valid();
      wait_for_drain();

      clock_ms = $urandom;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 63;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 63;
            end
            default: begin
               send_idle_pct = 30;
               rsp_stall_pct = 30;
            end
         endcase
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            random_item(counted);
            if (counted) count++;
         end
         lower_valid();
         wait_for_drain();
      end

      if (sb.error_count == 0 && sb.due_results.size() == 0) begin
         $display("timed_event_priority_queue_unit_tb: clean");
      end else begin
         $display("timed_event_priority_queue_unit_tb: errors");
      end
      $finish;
   end

endmodule
